FILE: design/isp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types, register codes, window masks and helpers for the isolated
// pixel removal filter.
// ----------------------------------------------------------------------------
package isp_pkg;

	// configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_MAX   = (2 ** CFG_W) - 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// frame geometry defaults
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int RESET_SIZE     = 1024;
	localparam int ROW_W          = 11;

	// request kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// 3x3 window bit groups: bit 4 is the centre, bits 8..6 the oldest column
	localparam logic [8:0] MASK_ALL    = 9'h1EF;
	localparam logic [8:0] MASK_RIGHT  = 9'h007;
	localparam logic [8:0] MASK_LEFT   = 9'h1C0;
	localparam logic [8:0] MASK_TOP    = 9'h124;
	localparam logic [8:0] MASK_BOTTOM = 9'h049;

	// control carried with a request in the first stage
	typedef struct packed {
		logic vld;
		logic emit;
		logic eof;
		logic pix;
		logic at_right;
		logic at_left;
		logic at_top;
		logic at_bottom;
	} isp_ctl_t;

	// zero reads as one, oversize saturates to the limit
	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] lim);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/isp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isp_if
// Valid/ready channels for the pixel stream and the filtered result stream.
// ----------------------------------------------------------------------------
interface isp_pix_if;
	logic valid;
	logic ready;
	logic kind;
	logic pixel_in;

	modport source(output valid, output kind, output pixel_in, input ready);
	modport sink(input valid, input kind, input pixel_in, output ready);
endinterface

interface isp_res_if;
	logic valid;
	logic ready;
	logic clean_pixel;
	logic end_of_frame;

	modport source(output valid, output clean_pixel, output end_of_frame, input ready);
	modport sink(input valid, input clean_pixel, input end_of_frame, output ready);
endinterface
`default_nettype wire

FILE: design/isp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isp_ctrl
// Frame size registers, input and result position counters, and the first
// pipeline stage that carries each request's control to the filter.
// ----------------------------------------------------------------------------
module isp_ctrl #(
	parameter int MAX_WIDTH  = isp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = isp_pkg::DEF_MAX_HEIGHT,
	parameter int COL_W      = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [isp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [isp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_kind,
	input  logic                          in_pixel,
	input  logic                          room,
	output isp_pkg::isp_ctl_t             ctl_s1,
	output logic [COL_W-1:0]              col_s1,
	output logic                          rd_en,
	output logic [COL_W-1:0]              rd_addr,
	output logic                          restart
);
	import isp_pkg::*;

	localparam int WLIM  = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
	localparam int HLIM  = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
	localparam int W_RST = (RESET_SIZE < WLIM) ? RESET_SIZE : WLIM;
	localparam int H_RST = (RESET_SIZE < HLIM) ? RESET_SIZE : HLIM;

	logic [CFG_W-1:0] w_q;
	logic [CFG_W-1:0] h_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] rcol_q;
	logic [ROW_W-1:0] rrow_q;

	logic     acc;
	logic     take;
	logic     in_frame;
	logic     col_last;
	logic     emit;
	logic     rcol_last;
	logic     rrow_last;
	logic     eof;
	isp_ctl_t ctl_d;

	// request acceptance and filtering of out-of-place pixels and flushes
	assign in_ready = !ctl_s1.vld || room;
	assign acc      = in_valid && in_ready;
	assign in_frame = row_q < h_q;
	assign take     = acc && ((in_kind == KIND_PIXEL) ? in_frame : !in_frame);

	// position flags
	assign col_last  = ((CFG_W + 1)'(col_q) + (CFG_W + 1)'(1)) >= {1'b0, w_q};
	assign emit      = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
	assign rcol_last = ((CFG_W + 1)'(rcol_q) + (CFG_W + 1)'(1)) >= {1'b0, w_q};
	assign rrow_last = ((ROW_W + 1)'(rrow_q) + (ROW_W + 1)'(1)) >= {1'b0, h_q};
	assign eof       = emit && rcol_last && rrow_last;

	assign restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
		(cfg_index == REG_FRAME_HEIGHT));
	assign rd_en   = take;
	assign rd_addr = col_q;

	// stage control for the filter
	always_comb begin
		ctl_d           = '0;
		ctl_d.vld       = take;
		ctl_d.emit      = emit;
		ctl_d.eof       = eof;
		ctl_d.pix       = (in_kind == KIND_PIXEL) ? in_pixel : 1'b0;
		ctl_d.at_right  = rcol_last;
		ctl_d.at_left   = (rcol_q == '0);
		ctl_d.at_top    = (rrow_q == '0);
		ctl_d.at_bottom = rrow_last;
	end

	// size registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= CFG_W'(W_RST);
			h_q    <= CFG_W'(H_RST);
			col_q  <= '0;
			row_q  <= '0;
			rcol_q <= '0;
			rrow_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: w_q <= clamp_size(cfg_data, CFG_W'(WLIM));
				REG_FRAME_HEIGHT: h_q <= clamp_size(cfg_data, CFG_W'(HLIM));
				default: ;
			endcase
			if (restart) begin
				col_q  <= '0;
				row_q  <= '0;
				rcol_q <= '0;
				rrow_q <= '0;
			end
		end else if (take) begin
			if (eof) begin
				col_q  <= '0;
				row_q  <= '0;
				rcol_q <= '0;
				rrow_q <= '0;
			end else begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				if (emit) begin
					if (rcol_last) begin
						rcol_q <= '0;
						rrow_q <= rrow_q + ROW_W'(1);
					end else begin
						rcol_q <= rcol_q + COL_W'(1);
					end
				end
			end
		end
	end

	// first stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (in_ready) begin
			ctl_s1 <= ctl_d;
		end
	end

	// first stage column
	always_ff @(posedge clk) begin
		if (take) begin
			col_s1 <= col_q;
		end
	end

endmodule
`default_nettype wire

FILE: design/isp_linebuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isp_linebuf
// Two one-bit line delays held as one two-bit-wide memory, read at request
// time and written when the request leaves the first stage, with a bypass
// for back-to-back access to the same column.
// ----------------------------------------------------------------------------
module isp_linebuf #(
	parameter int DEPTH  = isp_pkg::DEF_MAX_WIDTH,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [1:0]        wr_data,
	output logic              up1,
	output logic              up2
);
	import isp_pkg::*;

	// bit 1 holds the older row, bit 0 the newer row
	logic [1:0] mem [DEPTH];
	logic [1:0] rd_q;
	logic [1:0] byp_d_q;
	logic       byp_q;
	logic [1:0] line;

	// memory port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// same-column bypass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	// bypass data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_d_q <= wr_data;
		end
	end

	assign line = byp_q ? byp_d_q : rd_q;
	assign up1  = line[0];
	assign up2  = line[1];

endmodule
`default_nettype wire

FILE: design/isp_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isp_filter
// 3x3 window shift register, frame-border masking and the keep decision for
// the centre pixel.
// ----------------------------------------------------------------------------
module isp_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  isp_pkg::isp_ctl_t ctl_s1,
	input  logic              up1,
	input  logic              up2,
	input  logic              move,
	input  logic              restart,
	output logic              push,
	output logic              push_keep,
	output logic              push_eof
);
	import isp_pkg::*;

	logic [8:0] win_q;
	logic [8:0] win_next;
	logic [8:0] mask;

	// new column enters at the low bits
	assign win_next = {win_q[5:0], up2, up1, ctl_s1.pix};

	// drop neighbours that fall outside the frame
	always_comb begin
		mask = MASK_ALL;
		if (ctl_s1.at_right) begin
			mask = mask & ~MASK_RIGHT;
		end
		if (ctl_s1.at_left) begin
			mask = mask & ~MASK_LEFT;
		end
		if (ctl_s1.at_top) begin
			mask = mask & ~MASK_TOP;
		end
		if (ctl_s1.at_bottom) begin
			mask = mask & ~MASK_BOTTOM;
		end
	end

	// keep decision
	assign push      = move && ctl_s1.emit;
	assign push_keep = win_next[4] && (|(win_next & mask));
	assign push_eof  = ctl_s1.eof;

	// window register, cleared on frame restart and after the end-of-frame request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (restart) begin
			win_q <= '0;
		end else if (move) begin
			win_q <= ctl_s1.eof ? 9'h000 : win_next;
		end
	end

endmodule
`default_nettype wire

FILE: design/isp_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isp_outbuf
// Result register with a skid entry, so the pipeline keeps taking requests
// while a result waits on the output.
// ----------------------------------------------------------------------------
module isp_outbuf (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      push_keep,
	input  logic      push_eof,
	output logic      room,
	isp_res_if.source res
);
	import isp_pkg::*;

	logic       main_v_q;
	logic       skid_v_q;
	logic [1:0] main_d_q;
	logic [1:0] skid_d_q;
	logic       pop;
	logic       load_main;

	assign pop       = main_v_q && res.ready;
	assign load_main = !main_v_q || pop;
	assign room      = !skid_v_q;

	assign res.valid        = main_v_q;
	assign res.clean_pixel  = main_d_q[1];
	assign res.end_of_frame = main_d_q[0];

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (load_main) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// result data
	always_ff @(posedge clk) begin
		if (load_main) begin
			main_d_q <= skid_v_q ? skid_d_q : {push_keep, push_eof};
		end else if (push) begin
			skid_d_q <= {push_keep, push_eof};
		end
	end

endmodule
`default_nettype wire

FILE: design/isolated_pixel_removal.sv
`timescale 1ns / 1ps
`default_nettype none
// Latency: a result passes the first-stage and result registers after the request
// that completes it; in stream terms a pixel's result leaves with the request one
// row plus one pixel later (frame_width + 1 flush requests drain the last row).
// Throughput: one request per cycle while results do not back up, limited by the single line-buffer port pair.
// Reset: asynchronous, frame size 1024 x 1024 (capped at the parameters); the
// line buffer has no clearing pass, rows not yet written this frame are masked.
// ----------------------------------------------------------------------------
// isolated_pixel_removal
// Streaming 3x3 filter that clears set pixels with no set neighbour inside
// the frame.
// ----------------------------------------------------------------------------
module isolated_pixel_removal #(
	parameter int MAX_WIDTH  = isp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = isp_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	isp_pix_if.sink                       pix_in,
	isp_res_if.source                     res_out,
	input  logic                          cfg_we,
	input  logic [isp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [isp_pkg::CFG_W-1:0]     cfg_data
);
	import isp_pkg::*;

	localparam int WLIM  = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
	localparam int COL_W = (WLIM > 1) ? $clog2(WLIM) : 1;

	isp_ctl_t         ctl_s1;
	logic [COL_W-1:0] col_s1;
	logic [COL_W-1:0] rd_addr;
	logic             rd_en;
	logic             restart;
	logic             room;
	logic             move;
	logic             up1;
	logic             up2;
	logic             push;
	logic             push_keep;
	logic             push_eof;

	// first stage advances when the output side has space
	assign move = ctl_s1.vld && room;

	// counters and first stage
	isp_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.COL_W     (COL_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (pix_in.valid),
		.in_ready (pix_in.ready),
		.in_kind  (pix_in.kind),
		.in_pixel (pix_in.pixel_in),
		.room     (room),
		.ctl_s1   (ctl_s1),
		.col_s1   (col_s1),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.restart  (restart)
	);

	// line delays
	isp_linebuf #(
		.DEPTH (WLIM),
		.ADDR_W(COL_W)
	) u_linebuf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.wr_en  (move),
		.wr_addr(col_s1),
		.wr_data({up1, ctl_s1.pix}),
		.up1    (up1),
		.up2    (up2)
	);

	// window and keep decision
	isp_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.up1      (up1),
		.up2      (up2),
		.move     (move),
		.restart  (restart),
		.push     (push),
		.push_keep(push_keep),
		.push_eof (push_eof)
	);

	// result register
	isp_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_keep(push_keep),
		.push_eof (push_eof),
		.room     (room),
		.res      (res_out)
	);

endmodule
`default_nettype wire

FILE: design/isp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isp_checker
// Port-level checks on the request and result channels of the filter.
// ----------------------------------------------------------------------------
module isp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_clean,
	input logic out_eof
);
	import isp_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_clean) && $stable(out_eof))
	else $error("result changed while stalled");

	// with nothing waiting on the output the input is never stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
	else $error("input stalled with empty output");

	// a new result always traces back to a taken request through the first-stage register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
	else $error("result without a request");

endmodule

bind isolated_pixel_removal isp_checker u_isp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pix_in.valid),
	.in_ready (pix_in.ready),
	.out_valid(res_out.valid),
	.out_ready(res_out.ready),
	.out_clean(res_out.clean_pixel),
	.out_eof  (res_out.end_of_frame)
);
`default_nettype wire
